/* design/eslp_pkg.sv */
// ----------------------------------------------------------------------------
// eslp_pkg
// Shared types and constants for the encoder slew-limited low-pass block.
// ----------------------------------------------------------------------------
package eslp_pkg;

  // field widths
  localparam int RAW_W = 12;
  localparam int OFS_W = 13;
  localparam int POS_W = 14;
  localparam int Q_W   = 30;

  // bus widths
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // wrap limits and slew limit in whole counts
  localparam int WRAP_HI    = 2048;
  localparam int WRAP_SPAN  = 4096;
  localparam int SLEW_LIMIT = 10;

  // filter weights in percent
  localparam int SLEW_OLD_PCT   = 97;
  localparam int SLEW_NEW_PCT   = 3;
  localparam int SMOOTH_OLD_PCT = 95;
  localparam int SMOOTH_NEW_PCT = 5;

  // saturation bounds of the fixed point state
  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_OFFSET    = 1'b0,
    REG_DIRECTION = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [OFS_W-1:0] position_offset;
    logic                    direction_negate;
  } cfg_t;

endpackage

/* design/eslp_cfg.sv */
// ----------------------------------------------------------------------------
// eslp_cfg
// APB register file holding the position offset and direction control.
// ----------------------------------------------------------------------------
module eslp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [eslp_pkg::APB_AW-1:0]  paddr,
  input  logic [eslp_pkg::APB_DW-1:0]  pwdata,
  output logic [eslp_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output eslp_pkg::cfg_t               cfg_o
);

  eslp_pkg::cfg_t   cfg_q, cfg_d;
  eslp_pkg::reg_idx_e reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = eslp_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        eslp_pkg::REG_OFFSET: begin
          cfg_d.position_offset = $signed(pwdata[eslp_pkg::OFS_W-1:0]);
        end
        eslp_pkg::REG_DIRECTION: begin
          cfg_d.direction_negate = pwdata[0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      eslp_pkg::REG_OFFSET: begin
        prdata = eslp_pkg::APB_DW'(cfg_q.position_offset);
      end
      eslp_pkg::REG_DIRECTION: begin
        prdata = {{(eslp_pkg::APB_DW-1){1'b0}}, cfg_q.direction_negate};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/eslp_core.sv */
// ----------------------------------------------------------------------------
// eslp_core
// Offset, wrap, slew limit and the two recursive averages for one sample.
// ----------------------------------------------------------------------------
module eslp_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [eslp_pkg::RAW_W-1:0]          raw_i,
  input  eslp_pkg::cfg_t                      cfg_i,
  output logic signed [eslp_pkg::POS_W-1:0]   limited_o,
  output logic signed [eslp_pkg::Q_W-1:0]     smoothed_o
);

  localparam int RW = 15;
  localparam int QW = ((eslp_pkg::OFS_W + FRACTION_BITS > eslp_pkg::Q_W) ?
                       eslp_pkg::OFS_W + FRACTION_BITS : eslp_pkg::Q_W) + 2;
  localparam int CW = FRACTION_BITS + 1;
  localparam int PW = QW + CW;

  localparam logic signed [CW-1:0] C_SLEW_OLD =
    CW'(((64'(eslp_pkg::SLEW_OLD_PCT) << FRACTION_BITS) + 64'd50) / 64'd100);
  localparam logic signed [CW-1:0] C_SLEW_NEW =
    CW'(((64'(eslp_pkg::SLEW_NEW_PCT) << FRACTION_BITS) + 64'd50) / 64'd100);
  localparam logic signed [CW-1:0] C_SMOOTH_OLD =
    CW'(((64'(eslp_pkg::SMOOTH_OLD_PCT) << FRACTION_BITS) + 64'd50) / 64'd100);
  localparam logic signed [CW-1:0] C_SMOOTH_NEW =
    CW'(((64'(eslp_pkg::SMOOTH_NEW_PCT) << FRACTION_BITS) + 64'd50) / 64'd100);

  localparam logic signed [QW-1:0] SLEW_Q  = QW'(eslp_pkg::SLEW_LIMIT) <<< FRACTION_BITS;
  localparam logic signed [RW-1:0] WRAP_HI = RW'(eslp_pkg::WRAP_HI);
  localparam logic signed [RW-1:0] WRAP_LO = -RW'(eslp_pkg::WRAP_HI);
  localparam logic signed [RW-1:0] SPAN    = RW'(eslp_pkg::WRAP_SPAN);
  localparam logic [FRACTION_BITS-1:0] FRAC_ZERO = '0;

  localparam logic signed [PW-1:0] SAT_HI = PW'(eslp_pkg::Q_MAX);
  localparam logic signed [PW-1:0] SAT_LO = PW'(eslp_pkg::Q_MIN);

  function automatic logic signed [eslp_pkg::Q_W-1:0] sat_q(
    input logic signed [PW-1:0] v
  );
    logic signed [eslp_pkg::Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = eslp_pkg::Q_MAX;
    end else if (v < SAT_LO) begin
      r = eslp_pkg::Q_MIN;
    end else begin
      r = v[eslp_pkg::Q_W-1:0];
    end
    return r;
  endfunction

  logic signed [eslp_pkg::Q_W-1:0] baseline_q, baseline_d;
  logic signed [eslp_pkg::Q_W-1:0] smooth_q, smooth_d;
  logic                            base_seeded_q, smooth_seeded_q;

  logic signed [RW-1:0] raw_s, reading;
  logic signed [QW-1:0] reading_q, base_cur, diff, limited_q, lim_int, lim_int_q;
  logic signed [PW-1:0] prod_b_old, prod_b_new, prod_s_old, prod_s_new;

  always_comb begin
    raw_s   = $signed({{(RW-eslp_pkg::RAW_W){1'b0}}, raw_i});
    reading = cfg_i.direction_negate ? -raw_s : raw_s;
    reading = reading - RW'(cfg_i.position_offset);
    if (reading > WRAP_HI) begin
      reading = reading - SPAN;
    end
    if (reading <= WRAP_LO) begin
      reading = reading + SPAN;
    end
    reading_q = QW'(reading) <<< FRACTION_BITS;

    // first sample seeds the baseline, so it passes unclamped
    base_cur = base_seeded_q ? QW'(baseline_q) : QW'(sat_q(PW'(reading_q)));
    diff     = reading_q - base_cur;
    if (diff >= SLEW_Q) begin
      limited_q = base_cur + SLEW_Q;
    end else if (diff <= -SLEW_Q) begin
      limited_q = base_cur - SLEW_Q;
    end else begin
      limited_q = reading_q;
    end

    // truncate toward zero
    lim_int = limited_q >>> FRACTION_BITS;
    if (limited_q[QW-1] && (limited_q[FRACTION_BITS-1:0] != FRAC_ZERO)) begin
      lim_int = lim_int + QW'(1);
    end
    lim_int_q = lim_int <<< FRACTION_BITS;

    prod_b_old = PW'(base_cur) * PW'(C_SLEW_OLD);
    prod_b_new = PW'(limited_q) * PW'(C_SLEW_NEW);
    baseline_d = sat_q((prod_b_old >>> FRACTION_BITS) + (prod_b_new >>> FRACTION_BITS));

    prod_s_old = PW'(smooth_q) * PW'(C_SMOOTH_OLD);
    prod_s_new = PW'(lim_int_q) * PW'(C_SMOOTH_NEW);
    if (smooth_seeded_q) begin
      smooth_d = sat_q((prod_s_old >>> FRACTION_BITS) + (prod_s_new >>> FRACTION_BITS));
    end else begin
      smooth_d = sat_q(PW'(lim_int_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q      <= '0;
      smooth_q        <= '0;
      base_seeded_q   <= 1'b0;
      smooth_seeded_q <= 1'b0;
    end else if (step_i) begin
      baseline_q      <= baseline_d;
      smooth_q        <= smooth_d;
      base_seeded_q   <= 1'b1;
      smooth_seeded_q <= 1'b1;
    end
  end

  assign limited_o  = lim_int[eslp_pkg::POS_W-1:0];
  assign smoothed_o = smooth_d;

endmodule

/* design/encoder_slew_limit_lowpass_top.sv */
// ----------------------------------------------------------------------------
// encoder_slew_limit_lowpass_top
// Encoder reading conditioner: offset, wrap, slew limit and low-pass filter.
// ----------------------------------------------------------------------------
// Each beat on the input carries one raw 12-bit encoder sample; each sample
// yields exactly one output beat with the slew-limited position and the
// low-pass filtered position in fixed point. A sample is registered on entry,
// the offset, wrap, clamp and both moving averages are computed from that
// register combinationally, and the result lands in an output register; a
// new sample is taken every clock while the output is not stalled. The
// throughput is set by the update of the two recursive filter registers,
// which advance once per sample. Program the offset and direction only
// while no beats are in flight.
module encoder_slew_limit_lowpass_top #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [eslp_pkg::APB_AW-1:0]         paddr,
  input  logic [eslp_pkg::APB_DW-1:0]         pwdata,
  output logic [eslp_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [eslp_pkg::RAW_W-1:0]          raw_position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [eslp_pkg::POS_W-1:0]   limited_position_o,
  output logic signed [eslp_pkg::Q_W-1:0]     smoothed_position_o
);

  eslp_pkg::cfg_t cfg;

  logic                              in_valid_q, in_valid_d;
  logic [eslp_pkg::RAW_W-1:0]        raw_q;
  logic                              out_valid_q, out_valid_d;
  logic signed [eslp_pkg::POS_W-1:0] limited_q;
  logic signed [eslp_pkg::Q_W-1:0]   smoothed_q;
  logic signed [eslp_pkg::POS_W-1:0] limited;
  logic signed [eslp_pkg::Q_W-1:0]   smoothed;
  logic                              accept, advance;

  eslp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  eslp_core #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .raw_i      (raw_q),
    .cfg_i      (cfg),
    .limited_o  (limited),
    .smoothed_o (smoothed)
  );

  // the sample moves on when the output register is free or being drained
  assign advance     = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~advance;
  assign accept      = in_valid_i & ~in_stall_o;
  assign in_valid_d  = accept | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= raw_position_i;
    end
    if (advance) begin
      limited_q  <= limited;
      smoothed_q <= smoothed;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign limited_position_o  = limited_q;
  assign smoothed_position_o = smoothed_q;

endmodule
